/* src/rbei_pkg.sv */
// ----------------------------------------------------------------------------
// rbei_pkg: shared types and helpers for the rigid body Euler integrator
// Fixed-point saturation, magnitude and the operation/status codes.
// ----------------------------------------------------------------------------
package rbei_pkg;

  localparam int MAX_BODIES_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DT_BITS        = 16;   // fraction bits of the time step

  // op codes
  localparam logic OP_STEP = 1'b0;
  localparam logic OP_LOAD = 1'b1;

  // body types
  localparam logic [1:0] BT_STATIC    = 2'd0;
  localparam logic [1:0] BT_KINEMATIC = 2'd1;
  localparam logic [1:0] BT_DYNAMIC   = 2'd2;
  localparam logic [1:0] BT_UNKNOWN   = 2'd3;

  // result status codes
  localparam logic [1:0] ST_UPDATED = 2'd0;
  localparam logic [1:0] ST_STATIC  = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;
  localparam logic [1:0] ST_LOADED  = 2'd3;

  // config register indexes
  localparam logic [1:0] REG_LIN_DAMP = 2'd0;
  localparam logic [1:0] REG_ANG_DAMP = 2'd1;
  localparam logic [1:0] REG_REST_THR = 2'd2;

  typedef struct packed {
    logic              ov;
    logic signed [31:0] val;
  } sat_t;

  // per-item bookkeeping carried alongside the datapath
  typedef struct packed {
    logic [7:0]         entity;
    logic [1:0]         status;
    logic               upd;    // pose advanced, rest snap applies
    logic               wr;     // velocity store written at the end
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [31:0] ph;
  } meta_t;

  // clamp to signed 32 bits
  function automatic sat_t sat32(input logic signed [65:0] v);
    sat_t r;
    r.ov  = (v > 66'sh0_7FFF_FFFF) || (v < -66'sh0_8000_0000);
    r.val = (v > 66'sh0_7FFF_FFFF) ? 32'sh7FFF_FFFF :
            (v < -66'sh0_8000_0000) ? 32'sh8000_0000 : 32'(v);
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

endpackage

/* src/rbei_vel_mem.sv */
// ----------------------------------------------------------------------------
// rbei_vel_mem: velocity store
// One write and one registered read port; zero sweep after reset.
// ----------------------------------------------------------------------------
module rbei_vel_mem #(
  parameter int Depth = rbei_pkg::MAX_BODIES_DEF,
  parameter int AW    = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [95:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [95:0]   rdata,
  output logic          busy
);
  import rbei_pkg::*;

  logic [95:0]   mem [Depth];
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(Depth - 1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (busy && !rst) mem[clr_addr] <= '0;
    else if (we) mem[waddr] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (re) rdata <= mem[raddr];
  end

endmodule

/* src/rbei_lane.sv */
// ----------------------------------------------------------------------------
// rbei_lane: one velocity axis
// Damping, force and dt multiply chain, then displacement and speed square.
// ----------------------------------------------------------------------------
module rbei_lane #(
  parameter int FracBits = rbei_pkg::FRAC_BITS_DEF
) (
  input  logic                        clk,
  input  logic [8:1]                  ld,      // stage k loads
  input  logic signed [31:0]          f_in,
  input  logic [31:0]                 r_in,
  input  logic [rbei_pkg::DT_BITS-1:0] dt_in,
  input  logic                        dyn_in,
  input  logic                        load_in,
  input  logic signed [31:0]          v_mem,   // stage 1, from store
  input  logic [31:0]                 damp,
  output logic signed [31:0]          step,    // stage 8
  output logic signed [31:0]          v_new,
  output logic [63:0]                 v_sq,
  output logic                        ovf
);
  import rbei_pkg::*;

  logic signed [31:0] f1, f2, v2, v3, v4, v5, v6, v7, v8, n3, a5;
  logic [31:0]        r1, r2, r3;
  logic [DT_BITS-1:0] dt1, dt2, dt3, dt4, dt5, dt6, dt7;
  logic               dyn1, dyn2, dyn3, dyn4, dyn5, dyn6, ld1;
  logic               fl3, fl4, fl5, fl6, fl7, fl8;
  logic signed [64:0] p1c, p2, p3c, p4, p5c, p6, p7c, p8;
  logic [63:0]        sqc, sq8;
  logic signed [31:0] v1, vn;
  logic [31:0]        mg;
  sat_t               d, n, a, b, s, st;

  // stage 1: velocity (or load value) times damping
  assign v1  = ld1 ? f1 : v_mem;
  assign p1c = v1 * $signed({1'b0, damp});
  // stage 2: net = force - damping term
  assign d = sat32(66'(p2 >>> FracBits));
  assign n = sat32(66'(f2) - 66'(d.val));
  // stage 3/4: acceleration
  assign p3c = n3 * $signed({1'b0, r3});
  assign a   = sat32(66'(p4 >>> FracBits));
  // stage 5/6: velocity update
  assign p5c = a5 * $signed({1'b0, dt5});
  assign b   = sat32(66'(p6 >>> DT_BITS));
  assign s   = sat32(66'(v6) + 66'(b.val));
  assign vn  = dyn6 ? s.val : v6;
  // stage 7/8: displacement and speed square
  assign p7c = v7 * $signed({1'b0, dt7});
  assign mg  = mag32(v7);
  assign sqc = mg * mg;
  assign st  = sat32(66'(p8 >>> DT_BITS));

  assign step  = st.val;
  assign v_new = v8;
  assign v_sq  = sq8;
  assign ovf   = fl8 | st.ov;

  always_ff @(posedge clk) begin
    if (ld[1]) begin
      f1 <= f_in; r1 <= r_in; dt1 <= dt_in; dyn1 <= dyn_in; ld1 <= load_in;
    end
    if (ld[2]) begin
      p2 <= p1c; f2 <= f1; r2 <= r1; dt2 <= dt1; dyn2 <= dyn1; v2 <= v1;
    end
    if (ld[3]) begin
      n3 <= n.val; r3 <= r2; dt3 <= dt2; dyn3 <= dyn2; v3 <= v2;
      fl3 <= dyn2 & (d.ov | n.ov);
    end
    if (ld[4]) begin
      p4 <= p3c; dt4 <= dt3; dyn4 <= dyn3; v4 <= v3; fl4 <= fl3;
    end
    if (ld[5]) begin
      a5 <= a.val; dt5 <= dt4; dyn5 <= dyn4; v5 <= v4;
      fl5 <= fl4 | (dyn4 & a.ov);
    end
    if (ld[6]) begin
      p6 <= p5c; dt6 <= dt5; dyn6 <= dyn5; v6 <= v5; fl6 <= fl5;
    end
    if (ld[7]) begin
      v7 <= vn; dt7 <= dt6; fl7 <= fl6 | (dyn6 & (b.ov | s.ov));
    end
    if (ld[8]) begin
      p8 <= p7c; sq8 <= sqc; v8 <= v7; fl8 <= fl7;
    end
  end

endmodule

/* src/rigid_body_euler_integrator_2d.sv */
// ----------------------------------------------------------------------------
// rigid_body_euler_integrator_2d: per-body 2D semi-implicit Euler step
// Q16.16 pose update with per-entity velocities held in an on-chip store.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one command beat per body (step or velocity load); m_* returns
//   exactly one result beat per command, in order. The APB port sets linear
//   and angular damping and the rest threshold; write it only while idle.
// Pipeline: stage 1 loads at acceptance, seven more datapath stages, each one
//   multiply deep, then the output register, which drives m_tvalid.
// Throughput: one beat per cycle unless a hazard, the store sweep or output
//   back-pressure stalls it. A beat for a body still in flight with a pending
//   store write waits until that write lands; the store is read at acceptance
//   and written as the item leaves stage 8, so no forwarding is needed.
// Reset: the velocity store is swept to zero, one entry per cycle, while
//   s_tready stays low. APB is live throughout.
// Stall: each stage advances when the next one is free, so bubbles collapse
//   and input fills empty stages while the output register waits on m_tready.
// ----------------------------------------------------------------------------
module rigid_body_euler_integrator_2d #(
  parameter int MAX_BODIES = rbei_pkg::MAX_BODIES_DEF,
  parameter int FRAC_BITS  = rbei_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  // tdata: entity[7:0], time_step[23:8], vec_x[55:24], vec_y[87:56],
  //   spin[119:88], pos_x[151:120], pos_y[183:152], heading[215:184],
  //   inv_mass[247:216], inv_inertia[279:248]
  input  logic [279:0] s_tdata,
  // tuser: op[0], body_type[2:1]
  input  logic [2:0]   s_tuser,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: entity_out[7:0], new_pos_x[39:8], new_pos_y[71:40],
  //   new_heading[103:72], step_x[135:104], step_y[167:136],
  //   step_turn[199:168]
  output logic [199:0] m_tdata,
  // tuser: status[1:0], saturated[2]
  output logic [2:0]   m_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // config
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [3:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);
  import rbei_pkg::*;

  localparam int AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;

  // ---------------- configuration ----------------
  logic [31:0] lin_damp, ang_damp, rest_thr;
  logic [63:0] rest_sq;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lin_damp <= '0;
      ang_damp <= '0;
      rest_thr <= 32'd66;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_LIN_DAMP: lin_damp <= pwdata;
        REG_ANG_DAMP: ang_damp <= pwdata;
        REG_REST_THR: rest_thr <= pwdata;
        default: ;
      endcase
    end
  end

  // threshold squared, registered from rest_thr
  always_ff @(posedge clk) rest_sq <= rest_thr * rest_thr;

  always_comb begin
    case (paddr[3:2])
      REG_LIN_DAMP: prdata = lin_damp;
      REG_ANG_DAMP: prdata = ang_damp;
      REG_REST_THR: prdata = rest_thr;
      default:      prdata = '0;
    endcase
  end

  // ---------------- input unpack ----------------
  logic               in_op;
  logic [1:0]         in_type;
  logic [7:0]         in_ent;
  logic [DT_BITS-1:0] in_dt;
  logic signed [31:0] in_vec [3];
  logic signed [31:0] in_pose [3];
  logic [31:0]        in_recip [3];
  logic [31:0]        lane_damp [3];

  assign in_op        = s_tuser[0];
  assign in_type      = s_tuser[2:1];
  assign in_ent       = s_tdata[7:0];
  assign in_dt        = s_tdata[23:8];
  assign in_vec[0]    = s_tdata[55:24];
  assign in_vec[1]    = s_tdata[87:56];
  assign in_vec[2]    = s_tdata[119:88];
  assign in_pose[0]   = s_tdata[151:120];
  assign in_pose[1]   = s_tdata[183:152];
  assign in_pose[2]   = s_tdata[215:184];
  assign in_recip[0]  = s_tdata[247:216];
  assign in_recip[1]  = s_tdata[247:216];
  assign in_recip[2]  = s_tdata[279:248];
  assign lane_damp[0] = lin_damp;
  assign lane_damp[1] = lin_damp;
  assign lane_damp[2] = ang_damp;

  // ---------------- pipeline control ----------------
  logic [9:1] valid;
  logic [9:1] go;     // item leaves stage k this cycle
  logic [9:1] free;   // stage k can take an item this cycle
  logic [8:1] ld;
  meta_t      meta [1:8];
  meta_t      meta_in;
  logic       in_ok, in_dyn, in_load, hazard, accept, mem_busy;

  always_comb begin
    free[9] = !valid[9] || m_tready;
    go[9]   = valid[9] && m_tready;
    for (int k = 8; k >= 1; k--) begin
      go[k]   = valid[k] && free[k+1];
      free[k] = !valid[k] || go[k];
    end
  end

  // hold a beat back while an older item for the same body still has to write
  always_comb begin
    hazard = 1'b0;
    for (int k = 1; k <= 8; k++) begin
      if (valid[k] && meta[k].wr && meta[k].entity == in_ent) hazard = 1'b1;
    end
  end

  assign s_tready = free[1] && !hazard && !mem_busy;
  assign accept   = s_tvalid && s_tready;

  assign ld[1] = accept;
  assign ld[8:2] = go[7:1];

  assign in_ok   = 32'(in_ent) < 32'(MAX_BODIES);
  assign in_load = (in_op == OP_LOAD);
  assign in_dyn  = (in_op == OP_STEP) && (in_type == BT_DYNAMIC);

  always_comb begin
    meta_in.entity = in_ent;
    meta_in.px     = in_pose[0];
    meta_in.py     = in_pose[1];
    meta_in.ph     = in_pose[2];
    meta_in.upd    = 1'b0;
    meta_in.wr     = 1'b0;
    if (in_load) begin
      meta_in.status = ST_LOADED;
      meta_in.wr     = in_ok;
    end else begin
      case (in_type)
        BT_STATIC:  meta_in.status = ST_STATIC;
        BT_UNKNOWN: meta_in.status = ST_UNKNOWN;
        default: begin
          meta_in.status = ST_UPDATED;
          meta_in.upd    = 1'b1;
          meta_in.wr     = in_ok;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      valid[1] <= accept | (valid[1] & !go[1]);
      for (int k = 2; k <= 9; k++) valid[k] <= go[k-1] | (valid[k] & !go[k]);
    end
  end

  // bookkeeping shift line, advances with the datapath
  logic       ok1;
  always_ff @(posedge clk) begin
    if (accept) begin
      meta[1] <= meta_in;
      ok1     <= in_ok;
    end
    for (int k = 2; k <= 8; k++) begin
      if (go[k-1]) meta[k] <= meta[k-1];
    end
  end

  // ---------------- velocity store ----------------
  logic        mem_we;
  logic [95:0] mem_wdata, mem_rdata;
  logic [AW-1:0] mem_waddr, mem_raddr;

  assign mem_raddr = AW'(in_ent);
  assign mem_waddr = AW'(meta[8].entity);
  assign mem_we    = go[8] && meta[8].wr;

  rbei_vel_mem #(.Depth(MAX_BODIES), .AW(AW)) u_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (mem_rdata),
    .busy  (mem_busy)
  );

  // ---------------- lanes: x, y, angular ----------------
  logic signed [31:0] lane_step [3];
  logic signed [31:0] lane_vnew [3];
  logic [63:0]        lane_sq [3];
  logic [2:0]         lane_ovf;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    logic signed [31:0] v_rd;
    // bodies beyond the store read as at rest
    assign v_rd = ok1 ? mem_rdata[32*g +: 32] : 32'sd0;

    rbei_lane #(.FracBits(FRAC_BITS)) u_lane (
      .clk     (clk),
      .ld      (ld),
      .f_in    (in_vec[g]),
      .r_in    (in_recip[g]),
      .dt_in   (in_dt),
      .dyn_in  (in_dyn),
      .load_in (in_load),
      .v_mem   (v_rd),
      .damp    (lane_damp[g]),
      .step    (lane_step[g]),
      .v_new   (lane_vnew[g]),
      .v_sq    (lane_sq[g]),
      .ovf     (lane_ovf[g])
    );
  end

  // ---------------- stage 8: pose, rest snap, write back ----------------
  sat_t        pose_new [3];
  logic [64:0] lin_sq;
  logic        lin_snap, ang_snap;

  assign pose_new[0] = sat32(66'(meta[8].px) + 66'(lane_step[0]));
  assign pose_new[1] = sat32(66'(meta[8].py) + 66'(lane_step[1]));
  assign pose_new[2] = sat32(66'(meta[8].ph) + 66'(lane_step[2]));

  // exact squared-speed compare, no root needed
  assign lin_sq   = 65'(lane_sq[0]) + 65'(lane_sq[1]);
  assign lin_snap = meta[8].upd && (lin_sq < 65'(rest_sq));
  assign ang_snap = meta[8].upd && (mag32(lane_vnew[2]) < rest_thr);

  assign mem_wdata = {ang_snap ? 32'sd0 : lane_vnew[2],
                      lin_snap ? 32'sd0 : lane_vnew[1],
                      lin_snap ? 32'sd0 : lane_vnew[0]};

  // ---------------- output register ----------------
  logic [7:0]         out_ent;
  logic [1:0]         out_status;
  logic               out_sat;
  logic signed [31:0] out_pose [3];
  logic signed [31:0] out_step [3];

  always_ff @(posedge clk) begin
    if (go[8]) begin
      out_ent    <= meta[8].entity;
      out_status <= meta[8].status;
      out_sat    <= meta[8].upd &&
                    ((|lane_ovf) || pose_new[0].ov || pose_new[1].ov || pose_new[2].ov);
      for (int i = 0; i < 3; i++) begin
        out_step[i] <= meta[8].upd ? lane_step[i] : 32'sd0;
      end
      out_pose[0] <= meta[8].upd ? pose_new[0].val : meta[8].px;
      out_pose[1] <= meta[8].upd ? pose_new[1].val : meta[8].py;
      out_pose[2] <= meta[8].upd ? pose_new[2].val : meta[8].ph;
    end
  end

  assign m_tvalid = valid[9];
  assign m_tdata  = {out_step[2], out_step[1], out_step[0],
                     out_pose[2], out_pose[1], out_pose[0], out_ent};
  assign m_tuser  = {out_sat, out_status};

`ifndef ASSERT_OFF
  // no beat is taken while the store is being swept
  a_no_accept_clear: assert property (@(posedge clk) disable iff (rst)
    mem_busy |-> !s_tready)
    else $error("beat accepted during store clear");

  // interlock: a read never meets a write to the same body in one cycle
  a_no_rw_clash: assert property (@(posedge clk) disable iff (rst)
    (mem_we && accept) |-> (mem_waddr != mem_raddr))
    else $error("store read and write collide");

  // every item reaching the output register was tracked through stage 8
  a_out_from_pipe: assert property (@(posedge clk) disable iff (rst)
    ($rose(valid[9])) |-> $past(valid[8]))
    else $error("result appeared without a source item");
`endif

endmodule
